// ===== rtl/periodic_task_dispatcher_unit_macros.svh =====
// Assertion macros used by the dispatcher back end.
`ifndef PERIODIC_TASK_DISPATCHER_UNIT_MACROS_SVH
`define PERIODIC_TASK_DISPATCHER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTD_ASSERT_SAME(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTD_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ptd_pkg.sv =====
// Package with the types and constants of the periodic task dispatcher.
`default_nettype none
package ptd_pkg;

	// Operation codes of an input item.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Fixed field widths and limits.
	localparam int INDEX_W     = 4;
	localparam int RANK_W      = 8;
	localparam int INTERVAL_W  = 31;
	localparam int TIME_W      = 32;
	localparam int COUNT_CFG_W = 5;
	localparam int READY_LIMIT = 16;
	localparam int QUEUE_DEPTH = 4;

	// One transfer from the scanner to the sorter.
	typedef struct packed {
		logic                mark;
		logic [INDEX_W-1:0]  idx;
		logic [RANK_W-1:0]   rank;
	} ptd_entry_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} ptd_q_status_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_ISSUE,
		F_CHECK,
		F_MARK
	} ptd_front_state_t;

	typedef enum logic {
		B_COLLECT,
		B_EMIT
	} ptd_back_state_t;

endpackage
`default_nettype wire

// ===== rtl/ptd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module ptd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ptd_front.sv =====
// Front end: accepts items, holds the slot tables and scans slots for due tasks.
`default_nettype none
module ptd_front #(
	parameter int MAX_TASKS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                accept,
	input  wire logic                                operation,
	input  wire logic [ptd_pkg::INDEX_W-1:0]         task_slot,
	input  wire logic [ptd_pkg::TIME_W-1:0]          time_us,
	input  wire logic [ptd_pkg::INTERVAL_W-1:0]      period_us,
	input  wire logic [ptd_pkg::RANK_W-1:0]          task_priority,
	input  wire logic                                enable,
	input  wire logic [ptd_pkg::COUNT_CFG_W-1:0]     tasks_in_use,
	input  wire ptd_pkg::ptd_q_status_t              q_status,
	output logic                                     push,
	output ptd_pkg::ptd_entry_t                      push_entry,
	output logic                                     busy
);

	localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int FW = $clog2(ptd_pkg::READY_LIMIT + 1);
	localparam int TW = ptd_pkg::INTERVAL_W + ptd_pkg::RANK_W;

	ptd_pkg::ptd_front_state_t state_q, state_d;

	logic [CW-1:0]                   slot_q;
	logic [CW-1:0]                   limit_q;
	logic [CW-1:0]                   limit_d;
	logic [FW-1:0]                   found_q;
	logic [ptd_pkg::TIME_W-1:0]      now_q;
	logic [MAX_TASKS-1:0]            active_q;

	logic                            slot_ok;
	logic                            load_wr;
	logic                            upd_wr;
	logic                            take;
	logic                            slot_due;
	logic                            rd_en;
	logic [ptd_pkg::TIME_W-1:0]      elapsed;
	logic [ptd_pkg::TIME_W-1:0]      rd_last;
	logic [TW-1:0]                   rd_task;
	logic                            last_we;
	logic [AW-1:0]                   last_waddr;
	logic [ptd_pkg::TIME_W-1:0]      last_wdata;

	// Load qualification and the clamped scan length.
	always_comb begin
		slot_ok = int'(task_slot) < MAX_TASKS;
		load_wr = accept && (operation == ptd_pkg::OP_LOAD) && slot_ok;
		if (int'(tasks_in_use) > MAX_TASKS) begin
			limit_d = CW'(MAX_TASKS);
		end else begin
			limit_d = CW'(tasks_in_use);
		end
	end

	// Wrap-safe due test on the slot data just read.
	always_comb begin
		elapsed  = now_q - rd_last;
		slot_due = active_q[slot_q[AW-1:0]] && !elapsed[ptd_pkg::TIME_W-1] &&
			(elapsed[ptd_pkg::INTERVAL_W-1:0] >= rd_task[TW-1:ptd_pkg::RANK_W]);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ptd_pkg::F_IDLE: begin
				if (accept && (operation == ptd_pkg::OP_TICK)) begin
					state_d = ptd_pkg::F_ISSUE;
				end
			end
			ptd_pkg::F_ISSUE: begin
				if (slot_q == limit_q) begin
					state_d = ptd_pkg::F_MARK;
				end else begin
					state_d = ptd_pkg::F_CHECK;
				end
			end
			ptd_pkg::F_CHECK: begin
				if (!(take && q_status.full)) begin
					state_d = ptd_pkg::F_ISSUE;
				end
			end
			ptd_pkg::F_MARK: begin
				if (!q_status.full) begin
					state_d = ptd_pkg::F_IDLE;
				end
			end
			default: state_d = ptd_pkg::F_IDLE;
		endcase
	end

	// Outputs of the scanner.
	always_comb begin
		busy  = state_q != ptd_pkg::F_IDLE;
		rd_en = (state_q == ptd_pkg::F_ISSUE) && (slot_q != limit_q);
		take  = (state_q == ptd_pkg::F_CHECK) && slot_due &&
			(found_q < FW'(ptd_pkg::READY_LIMIT));
		upd_wr = take && !q_status.full;
		push   = upd_wr || ((state_q == ptd_pkg::F_MARK) && !q_status.full);
		push_entry.mark = state_q == ptd_pkg::F_MARK;
		push_entry.idx  = ptd_pkg::INDEX_W'(slot_q);
		push_entry.rank = rd_task[ptd_pkg::RANK_W-1:0];
		last_we    = load_wr || upd_wr;
		last_waddr = upd_wr ? slot_q[AW-1:0] : AW'(task_slot);
		last_wdata = upd_wr ? now_q : time_us;
	end

	// Control registers and the active flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ptd_pkg::F_IDLE;
			slot_q   <= '0;
			found_q  <= '0;
			active_q <= '0;
		end else begin
			state_q <= state_d;
			if (load_wr) begin
				active_q[AW'(task_slot)] <= enable;
			end
			if ((state_q == ptd_pkg::F_IDLE) && (state_d == ptd_pkg::F_ISSUE)) begin
				slot_q  <= '0;
				found_q <= '0;
			end else if ((state_q == ptd_pkg::F_CHECK) && (state_d == ptd_pkg::F_ISSUE)) begin
				slot_q <= slot_q + CW'(1);
				if (upd_wr) begin
					found_q <= found_q + FW'(1);
				end
			end
		end
	end

	// Tick time and scan length for the run in progress.
	always_ff @(posedge clk) begin
		if ((state_q == ptd_pkg::F_IDLE) && (state_d == ptd_pkg::F_ISSUE)) begin
			now_q   <= time_us;
			limit_q <= limit_d;
		end
	end

	// Last dispatch times, written by loads and by dispatches.
	ptd_ram #(
		.WIDTH(ptd_pkg::TIME_W),
		.DEPTH(MAX_TASKS)
	) u_last_ram (
		.clk  (clk),
		.we   (last_we),
		.waddr(last_waddr),
		.wdata(last_wdata),
		.re   (rd_en),
		.raddr(slot_q[AW-1:0]),
		.rdata(rd_last)
	);

	// Interval and rank, written by loads only.
	ptd_ram #(
		.WIDTH(TW),
		.DEPTH(MAX_TASKS)
	) u_task_ram (
		.clk  (clk),
		.we   (load_wr),
		.waddr(AW'(task_slot)),
		.wdata({period_us, task_priority}),
		.re   (rd_en),
		.raddr(slot_q[AW-1:0]),
		.rdata(rd_task)
	);

endmodule
`default_nettype wire

// ===== rtl/ptd_queue.sv =====
// Short queue carrying due slots from the scanner to the sorter.
`default_nettype none
module ptd_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire ptd_pkg::ptd_entry_t   push_entry,
	input  wire logic                  pop,
	output ptd_pkg::ptd_entry_t        head,
	output ptd_pkg::ptd_q_status_t     status
);

	localparam int PW = $clog2(ptd_pkg::QUEUE_DEPTH);
	localparam int NW = $clog2(ptd_pkg::QUEUE_DEPTH + 1);

	ptd_pkg::ptd_entry_t entries_q [ptd_pkg::QUEUE_DEPTH];
	logic [PW-1:0]       wr_ptr_q;
	logic [PW-1:0]       rd_ptr_q;
	logic [NW-1:0]       count_q;

	// Status and head of the queue.
	always_comb begin
		status.full  = count_q == NW'(ptd_pkg::QUEUE_DEPTH);
		status.empty = count_q == '0;
		head         = entries_q[rd_ptr_q];
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ptd_back.sv =====
// Back end: sorts the due slots of a tick by rank and delivers the results.
`default_nettype none
`include "periodic_task_dispatcher_unit_macros.svh"
module ptd_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ptd_pkg::ptd_entry_t           head,
	input  wire ptd_pkg::ptd_q_status_t        q_status,
	output logic                               pop,
	output logic                               busy,
	output logic                               result_strobe,
	output logic [ptd_pkg::INDEX_W-1:0]        task_index,
	output logic                               dispatched,
	output logic                               last_of_tick
);

	localparam int LN = ptd_pkg::READY_LIMIT;
	localparam int NW = $clog2(LN + 1);

	ptd_pkg::ptd_back_state_t state_q, state_d;

	logic [ptd_pkg::RANK_W-1:0]  rank_q [LN];
	logic [ptd_pkg::INDEX_W-1:0] idx_q  [LN];
	logic [NW-1:0]               count_q;
	logic [LN-1:0]               gt;
	logic                        insert;

	// Entries ranked strictly above the newcomer move one place down.
	always_comb begin
		for (int k = 0; k < LN; k++) begin
			gt[k] = (k < int'(count_q)) && (rank_q[k] > head.rank);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ptd_pkg::B_COLLECT: begin
				if (!q_status.empty && head.mark) begin
					state_d = ptd_pkg::B_EMIT;
				end
			end
			ptd_pkg::B_EMIT: begin
				if (count_q <= NW'(1)) begin
					state_d = ptd_pkg::B_COLLECT;
				end
			end
			default: state_d = ptd_pkg::B_COLLECT;
		endcase
	end

	// Handshake outputs.
	always_comb begin
		pop    = (state_q == ptd_pkg::B_COLLECT) && !q_status.empty;
		insert = pop && !head.mark;
		busy   = state_q == ptd_pkg::B_EMIT;
	end

	// Control state and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ptd_pkg::B_COLLECT;
			count_q       <= '0;
			result_strobe <= 1'b0;
		end else begin
			state_q       <= state_d;
			result_strobe <= state_q == ptd_pkg::B_EMIT;
			if (insert) begin
				count_q <= count_q + NW'(1);
			end else if ((state_q == ptd_pkg::B_EMIT) && (count_q != '0)) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	// Sorted list and the result payload.
	always_ff @(posedge clk) begin
		if (insert) begin
			for (int k = 0; k < LN; k++) begin
				if ((k > 0) && gt[(k > 0) ? k - 1 : 0]) begin
					rank_q[k] <= rank_q[(k > 0) ? k - 1 : 0];
					idx_q[k]  <= idx_q[(k > 0) ? k - 1 : 0];
				end else if (gt[k] || (k == int'(count_q))) begin
					rank_q[k] <= head.rank;
					idx_q[k]  <= head.idx;
				end
			end
		end else if (state_q == ptd_pkg::B_EMIT) begin
			for (int k = 0; k < LN - 1; k++) begin
				rank_q[k] <= rank_q[k + 1];
				idx_q[k]  <= idx_q[k + 1];
			end
		end
		if (state_q == ptd_pkg::B_EMIT) begin
			if (count_q == '0) begin
				task_index   <= '0;
				dispatched   <= 1'b0;
				last_of_tick <= 1'b1;
			end else begin
				task_index   <= idx_q[0];
				dispatched   <= 1'b1;
				last_of_tick <= count_q == NW'(1);
			end
		end
	end

	`PTD_ASSERT_NEXT(a_gap_after_last, result_strobe && last_of_tick, !result_strobe,
		"result strobe straight after the last result of a tick")
	`PTD_ASSERT_SAME(a_no_pop_in_emit, state_q == ptd_pkg::B_EMIT, !pop,
		"queue popped while results are being delivered")
	`PTD_ASSERT_SAME(a_empty_result, result_strobe && !dispatched,
		last_of_tick && (task_index == '0), "empty result not marked as final")

endmodule
`default_nettype wire

// ===== rtl/periodic_task_dispatcher_unit.sv =====
// Load item: writes its slot when it is taken and gives no result.
// Tick item: each scanned slot goes through the registered table read and the
// due check, then the results are issued one per cycle. The next item is
// taken once the last result has been issued. Results cannot be stalled by
// the receiver. Reset clears the task count, every active flag and all control
// state.
`default_nettype none
module periodic_task_dispatcher_unit #(
	parameter int MAX_TASKS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                operation,
	input  wire logic [ptd_pkg::INDEX_W-1:0]         task_slot,
	input  wire logic [ptd_pkg::TIME_W-1:0]          time_us,
	input  wire logic [ptd_pkg::INTERVAL_W-1:0]      period_us,
	input  wire logic [ptd_pkg::RANK_W-1:0]          task_priority,
	input  wire logic                                enable,
	input  wire logic                                cfg_we,
	input  wire logic [ptd_pkg::COUNT_CFG_W-1:0]     cfg_wdata,
	output logic                                     result_strobe,
	output logic [ptd_pkg::INDEX_W-1:0]              task_index,
	output logic                                     dispatched,
	output logic                                     last_of_tick
);

	logic [ptd_pkg::COUNT_CFG_W-1:0] tasks_in_use_q;
	logic                            accept;
	logic                            front_busy;
	logic                            back_busy;
	logic                            push;
	logic                            pop;
	ptd_pkg::ptd_entry_t             push_entry;
	ptd_pkg::ptd_entry_t             head;
	ptd_pkg::ptd_q_status_t          q_status;

	// Busy while any part of the block still holds work.
	always_comb begin
		busy   = front_busy || !q_status.empty || back_busy;
		accept = start && !busy;
	end

	// Task count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tasks_in_use_q <= '0;
		end else if (cfg_we) begin
			tasks_in_use_q <= cfg_wdata;
		end
	end

	ptd_front #(
		.MAX_TASKS(MAX_TASKS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.operation    (operation),
		.task_slot    (task_slot),
		.time_us      (time_us),
		.period_us    (period_us),
		.task_priority(task_priority),
		.enable       (enable),
		.tasks_in_use (tasks_in_use_q),
		.q_status     (q_status),
		.push         (push),
		.push_entry   (push_entry),
		.busy         (front_busy)
	);

	ptd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	ptd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.busy         (back_busy),
		.result_strobe(result_strobe),
		.task_index   (task_index),
		.dispatched   (dispatched),
		.last_of_tick (last_of_tick)
	);

endmodule
`default_nettype wire

// ===== tb/sv/tb_periodic_task_dispatcher_unit.sv =====
// Self-checking testbench for the periodic task dispatcher unit.
`timescale 1ns / 100ps
module tb_periodic_task_dispatcher_unit;

	localparam int SLOTS        = 16;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int RANDOM_ITEMS = 330;
	localparam int CALM_ITEMS   = 40;
	localparam int REPORT_LIMIT = 10;
	localparam int IW           = ptd_pkg::INDEX_W;
	localparam int TMW          = ptd_pkg::TIME_W;
	localparam int PW           = ptd_pkg::INTERVAL_W;
	localparam int RW           = ptd_pkg::RANK_W;
	localparam int NW           = ptd_pkg::COUNT_CFG_W;

	typedef enum logic {
		ROW_CONFIG,
		ROW_ITEM
	} row_kind_t;

	// One input item as it is presented on the command ports.
	typedef struct packed {
		logic           op;
		logic [IW-1:0]  slot;
		logic [TMW-1:0] stamp;
		logic [PW-1:0]  interval;
		logic [RW-1:0]  rank;
		logic           en;
	} task_item_t;

	// One result transfer.
	typedef struct packed {
		logic [IW-1:0] idx;
		logic          hit;
		logic          last;
	} dispatch_t;

	// One row of the directed stimulus.
	typedef struct packed {
		row_kind_t     kind;
		logic [NW-1:0] count;
		task_item_t    item;
		logic          typed;
		dispatch_t     result;
	} stim_row_t;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	logic           operation;
	logic [IW-1:0]  task_slot;
	logic [TMW-1:0] time_us;
	logic [PW-1:0]  period_us;
	logic [RW-1:0]  task_priority;
	logic           enable;
	logic           cfg_we;
	logic [NW-1:0]  cfg_wdata;
	logic           result_strobe;
	logic [IW-1:0]  task_index;
	logic           dispatched;
	logic           last_of_tick;

	// Shadow copy of the task table and the scan count.
	logic [PW-1:0]  shadow_interval [SLOTS];
	logic [RW-1:0]  shadow_rank [SLOTS];
	logic           shadow_active [SLOTS];
	logic [TMW-1:0] shadow_last [SLOTS];
	logic [NW-1:0]  shadow_count;

	dispatch_t   pending_dispatches [$];
	stim_row_t   directed_rows [$];
	logic [31:0] tick_base;
	int          fail_count;
	int          random_sent;
	int          cycle_count;

	periodic_task_dispatcher_unit #(
		.MAX_TASKS(SLOTS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.task_slot(task_slot),
		.time_us(time_us),
		.period_us(period_us),
		.task_priority(task_priority),
		.enable(enable),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.result_strobe(result_strobe),
		.task_index(task_index),
		.dispatched(dispatched),
		.last_of_tick(last_of_tick)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Guard against a hung run.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Works out the dispatch order for one item and updates the shadow table.
	function automatic void predict_dispatch(input task_item_t it, output dispatch_t res[$]);
		int             order [$];
		int             span;
		int             s;
		int             i;
		int             k;
		int             cur;
		logic [TMW-1:0] elapsed;
		res = {};
		if (it.op == ptd_pkg::OP_LOAD) begin
			shadow_last[it.slot]     = it.stamp;
			shadow_interval[it.slot] = it.interval;
			shadow_rank[it.slot]     = it.rank;
			shadow_active[it.slot]   = it.en;
			return;
		end
		span = (shadow_count > SLOTS) ? SLOTS : int'(shadow_count);
		for (s = 0; s < span; s++) begin
			elapsed = it.stamp - shadow_last[s];
			// A negative elapsed time, read as two's complement, is never due.
			if (shadow_active[s] && !elapsed[TMW-1] &&
			    elapsed >= {1'b0, shadow_interval[s]} &&
			    order.size() < ptd_pkg::READY_LIMIT)
				order.push_back(s);
		end
		if (order.size() == 0) begin
			res.push_back(dispatch_t'{idx: '0, hit: 1'b0, last: 1'b1});
			return;
		end
		// Stable insertion sort on rank keeps equal ranks in slot order.
		for (i = 1; i < order.size(); i++) begin
			cur = order[i];
			k = i;
			while (k > 0 && shadow_rank[order[k-1]] > shadow_rank[cur]) begin
				order[k] = order[k-1];
				k--;
			end
			order[k] = cur;
		end
		for (i = 0; i < order.size(); i++) begin
			shadow_last[order[i]] = it.stamp;
			res.push_back(dispatch_t'{idx: IW'(order[i]), hit: 1'b1,
				last: (i == order.size() - 1)});
		end
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endfunction

	// Result checker: every strobe is matched against the oldest expectation.
	always @(posedge clk) begin
		dispatch_t seen;
		dispatch_t want;
		if (arst_n && result_strobe) begin
			seen = '{idx: task_index, hit: dispatched, last: last_of_tick};
			if (pending_dispatches.size() == 0) begin
				note_failure($sformatf(
					"result with nothing expected: index %0d dispatched %0b last %0b",
					seen.idx, seen.hit, seen.last));
			end else begin
				want = pending_dispatches.pop_front();
				if (seen.idx !== want.idx || seen.hit !== want.hit || seen.last !== want.last)
					note_failure($sformatf({"expected index %0d dispatched %0b last %0b, ",
						"got index %0d dispatched %0b last %0b"},
						want.idx, want.hit, want.last, seen.idx, seen.hit, seen.last));
			end
		end
	end

	// Idle the command side; the fields carry noise that must be ignored.
	task automatic hold_off(input int cycles);
		start         = 1'b0;
		operation     = 1'($urandom);
		task_slot     = IW'($urandom);
		time_us       = $urandom;
		period_us     = PW'($urandom);
		task_priority = RW'($urandom);
		enable        = 1'($urandom);
		repeat (cycles) @(negedge clk);
	endtask

	// Presents one item and waits for its transfer; called at a falling edge.
	task automatic transfer_item(input task_item_t it, input logic typed, input dispatch_t fixed);
		dispatch_t res [$];
		start         = 1'b1;
		operation     = it.op;
		task_slot     = it.slot;
		time_us       = it.stamp;
		period_us     = it.interval;
		task_priority = it.rank;
		enable        = it.en;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_dispatch(it, res);
		if (typed && it.op == ptd_pkg::OP_TICK)
			pending_dispatches.push_back(fixed);
		else
			foreach (res[i])
				pending_dispatches.push_back(res[i]);
		@(negedge clk);
	endtask

	// Writes the scan count once the block has drained.
	task automatic write_count(input logic [NW-1:0] value);
		start = 1'b0;
		while (pending_dispatches.size() != 0 || busy)
			@(negedge clk);
		// A trailing load may still be in progress without any result to show it.
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we       = 1'b1;
		cfg_wdata    = value;
		shadow_count = value;
		@(negedge clk);
		cfg_we    = 1'b0;
		cfg_wdata = NW'($urandom);
	endtask

	// Random item with an occasional idle burst ahead of it.
	task automatic send_random(input task_item_t it);
		if (random_sent < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
			hold_off($urandom_range(1, 19));
		transfer_item(it, 1'b0, '0);
		random_sent++;
	endtask

	function automatic task_item_t random_load(input logic [IW-1:0] slot);
		task_item_t it;
		it.op   = ptd_pkg::OP_LOAD;
		it.slot = slot;
		if ($urandom_range(0, 9) == 0)
			it.stamp = $urandom;
		else
			it.stamp = tick_base - $urandom_range(0, 400);
		case ($urandom_range(0, 9))
			0: begin
				it.interval = PW'($urandom);
			end
			1: begin
				it.interval = '1;
			end
			2: begin
				it.interval = '0;
			end
			default: begin
				it.interval = PW'($urandom_range(0, 300));
			end
		endcase
		if ($urandom_range(0, 3) == 0)
			it.rank = RW'($urandom);
		else
			it.rank = RW'($urandom_range(0, 3));
		it.en = ($urandom_range(0, 7) != 0);
		return it;
	endfunction

	// Tick time mostly moves forward, sometimes jumps or steps back.
	function automatic task_item_t random_tick();
		task_item_t it;
		case ($urandom_range(0, 11))
			0: begin
				tick_base = $urandom;
			end
			1: begin
				tick_base = tick_base - $urandom_range(1, 500);
			end
			default: begin
				tick_base = tick_base + $urandom_range(0, 250);
			end
		endcase
		it.op       = ptd_pkg::OP_TICK;
		it.slot     = IW'($urandom);
		it.stamp    = tick_base;
		it.interval = PW'($urandom);
		it.rank     = RW'($urandom);
		it.en       = 1'($urandom);
		return it;
	endfunction

	function automatic task_item_t noise_item();
		task_item_t it;
		it.op       = 1'($urandom);
		it.slot     = IW'($urandom);
		it.stamp    = $urandom;
		it.interval = PW'($urandom);
		it.rank     = RW'($urandom);
		it.en       = 1'($urandom);
		return it;
	endfunction

	function automatic void add_config(input logic [NW-1:0] value);
		stim_row_t row;
		row       = '0;
		row.kind  = ROW_CONFIG;
		row.count = value;
		directed_rows.push_back(row);
	endfunction

	function automatic void add_item(input logic op, input logic [IW-1:0] slot,
		input logic [TMW-1:0] stamp, input logic [PW-1:0] interval,
		input logic [RW-1:0] rank, input logic en);
		stim_row_t row;
		row      = '0;
		row.kind = ROW_ITEM;
		row.item = '{op: op, slot: slot, stamp: stamp, interval: interval, rank: rank, en: en};
		directed_rows.push_back(row);
	endfunction

	// Tick whose single result is known by inspection.
	function automatic void add_checked_tick(input logic [TMW-1:0] stamp,
		input logic [IW-1:0] idx, input logic hit, input logic last);
		add_item(ptd_pkg::OP_TICK, '0, stamp, '0, '0, 1'b0);
		directed_rows[$].typed  = 1'b1;
		directed_rows[$].result = '{idx: idx, hit: hit, last: last};
	endfunction

	// Main stimulus.
	initial begin
		stim_row_t     row;
		task_item_t    it;
		int            phase;
		int            mode;
		int            s;
		logic [NW-1:0] count;
		logic [RW-1:0] shared_rank;

		arst_n      = 1'b0;
		start       = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		operation   = ptd_pkg::OP_LOAD;
		task_slot   = '0;
		time_us     = '0;
		period_us   = '0;
		task_priority = '0;
		enable      = 1'b0;
		fail_count  = 0;
		random_sent = 0;
		tick_base   = '0;
		for (s = 0; s < SLOTS; s++) begin
			shadow_interval[s] = '0;
			shadow_rank[s]     = '0;
			shadow_active[s]   = 1'b0;
			shadow_last[s]     = '0;
		end
		shadow_count = '0;

		// Nothing is scanned straight after reset.
		add_checked_tick(32'd0, 4'd0, 1'b0, 1'b1);
		add_config(5'd16);
		add_item(ptd_pkg::OP_LOAD, 4'd0, 32'd0, 31'd0, 8'd0, 1'b1);
		add_item(ptd_pkg::OP_LOAD, 4'd15, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'hFF, 1'b1);
		add_item(ptd_pkg::OP_LOAD, 4'd3, 32'd100, 31'd50, 8'd5, 1'b1);
		add_item(ptd_pkg::OP_LOAD, 4'd7, 32'd100, 31'd50, 8'd5, 1'b1);
		add_item(ptd_pkg::OP_LOAD, 4'd9, 32'd0, 31'd0, 8'd0, 1'b0);
		// Equal ranks on slots three and seven go out in slot order.
		add_item(ptd_pkg::OP_TICK, 4'd0, 32'd200, 31'd0, 8'd0, 1'b0);
		// Time running backwards leaves nothing due.
		add_checked_tick(32'd150, 4'd0, 1'b0, 1'b1);
		add_item(ptd_pkg::OP_TICK, 4'd15, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 8'hFF, 1'b1);
		// The largest interval is met exactly at the largest positive elapsed time.
		add_checked_tick(32'h7FFF_FFFE, 4'd15, 1'b1, 1'b1);
		// A count above the table size scans the whole table.
		add_config(5'd31);
		add_item(ptd_pkg::OP_LOAD, 4'd12, 32'h7FFF_FFF0, 31'd0, 8'd0, 1'b1);
		add_item(ptd_pkg::OP_TICK, 4'd0, 32'h8000_0010, 31'd0, 8'd0, 1'b0);
		add_config(5'd1);
		add_item(ptd_pkg::OP_LOAD, 4'd0, 32'h8000_0010, 31'd8, 8'd9, 1'b1);
		// One microsecond short of the interval, then exactly on it.
		add_checked_tick(32'h8000_0017, 4'd0, 1'b0, 1'b1);
		add_checked_tick(32'h8000_0018, 4'd0, 1'b1, 1'b1);
		add_config(5'd0);
		add_checked_tick(32'h9000_0000, 4'd0, 1'b0, 1'b1);

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part.
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_CONFIG)
				write_count(row.count);
			else
				transfer_item(row.item, row.typed, row.result);
		end

		// Random part: each phase sets a count and runs a few task sequences.
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			case (phase)
				0: begin
					count = 5'd16;
				end
				1: begin
					count = 5'd31;
				end
				2: begin
					count = 5'd0;
				end
				3: begin
					count = 5'd1;
				end
				4: begin
					count = 5'd15;
				end
				default: begin
					count = NW'($urandom_range(0, 31));
				end
			endcase
			write_count(count);
			if ($urandom_range(0, 3) == 0)
				tick_base = 32'hFFFF_FE00 + $urandom_range(0, 255);
			else
				tick_base = $urandom;
			repeat ($urandom_range(3, 6)) begin
				mode = $urandom_range(0, 9);
				if (mode == 0) begin
					// Noise with every field random.
					repeat ($urandom_range(2, 6))
						send_random(noise_item());
				end else if (mode == 1) begin
					// Fill every slot so that a single tick dispatches every slot within the scan count.
					shared_rank = RW'($urandom_range(0, 2));
					for (s = 0; s < SLOTS; s++) begin
						it          = random_load(IW'(s));
						it.stamp    = tick_base;
						it.interval = PW'($urandom_range(0, 20));
						it.rank     = ($urandom_range(0, 1) == 0) ? shared_rank : it.rank;
						it.en       = 1'b1;
						send_random(it);
					end
					tick_base = tick_base + 32'd50;
					it        = random_tick();
					it.stamp  = tick_base;
					send_random(it);
				end else if (mode == 2) begin
					// Ticks without fresh loads.
					repeat ($urandom_range(2, 5))
						send_random(random_tick());
				end else begin
					repeat ($urandom_range(1, 5))
						send_random(random_load(IW'($urandom)));
					repeat ($urandom_range(2, 5))
						send_random(random_tick());
				end
			end
			phase++;
		end

		// Let the last results arrive, then watch for strays.
		start = 1'b0;
		while (pending_dispatches.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		fail_count += pending_dispatches.size();
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ptd_pkg.sv
rtl/ptd_ram.sv
rtl/ptd_front.sv
rtl/ptd_queue.sv
rtl/ptd_back.sv
rtl/periodic_task_dispatcher_unit.sv
tb/sv/tb_periodic_task_dispatcher_unit.sv
